[rtl/core/ibh_pkg.sv]
package ibh_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned IdW   = 8;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned StatW = 3;
  localparam int unsigned CntW  = 9;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_PEEK   = 3'd3,
    CMD_POP    = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS,
    S_SLOT,
    S_DECIDE,
    S_UP,
    S_UP_CMP,
    S_DN,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  // one datapath operation per controller state
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_POS,
    OP_SLOT,
    OP_DECIDE,
    OP_UP_RD,
    OP_UP_CMP,
    OP_DN_RD,
    OP_DN_CMP,
    OP_PLACE,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic sift_go;
    logic hole_root;
    logic up_move;
    logic dn_leaf;
    logic dn_move;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/core/ibh_cmd_if.sv]
interface ibh_cmd_if;
  import ibh_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CmdW-1:0]        cmd;
  logic [IdW-1:0]         node_id;
  logic signed [KeyW-1:0] key;

  modport source (output valid, cmd, node_id, key, input ready);
  modport sink (input valid, cmd, node_id, key, output ready);
endinterface

[rtl/core/ibh_res_if.sv]
interface ibh_res_if;
  import ibh_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [IdW-1:0]         out_id;
  logic signed [KeyW-1:0] out_key;
  logic [StatW-1:0]       status;
  logic [CntW-1:0]        count_out;

  modport source (output valid, out_id, out_key, status, count_out, input ready);
  modport sink (input valid, out_id, out_key, status, count_out, output ready);
endinterface

[rtl/core/ibh_ctrl.sv]
module ibh_ctrl
  import ibh_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_op_e   op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_POS;
      S_POS:    state_d = S_SLOT;
      S_SLOT:   state_d = S_DECIDE;
      S_DECIDE: state_d = stat_i.sift_go ? S_UP : S_DONE;
      S_UP:     state_d = stat_i.hole_root ? S_DN : S_UP_CMP;
      S_UP_CMP: state_d = stat_i.up_move ? S_UP : S_DN;
      S_DN:     state_d = stat_i.dn_leaf ? S_PLACE : S_DN_CMP;
      S_DN_CMP: state_d = stat_i.dn_move ? S_DN : S_PLACE;
      S_PLACE:  state_d = S_DONE;
      S_DONE:   if (stat_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    op_o       = OP_IDLE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        op_o       = OP_IDLE;
      end
      S_POS:    op_o = OP_POS;
      S_SLOT:   op_o = OP_SLOT;
      S_DECIDE: op_o = OP_DECIDE;
      S_UP:     op_o = OP_UP_RD;
      S_UP_CMP: op_o = OP_UP_CMP;
      S_DN:     op_o = OP_DN_RD;
      S_DN_CMP: op_o = OP_DN_CMP;
      S_PLACE:  op_o = OP_PLACE;
      S_DONE:   op_o = OP_FINISH;
      default:  op_o = OP_IDLE;
    endcase
  end

endmodule

[rtl/core/ibh_datapath.sv]
module ibh_datapath
  import ibh_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int ID_COUNT = 256,
  parameter int KEY_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   in_xfer_i,
  input  logic [CmdW-1:0]        cmd_i,
  input  logic [IdW-1:0]         node_id_i,
  input  logic signed [KeyW-1:0] key_i,
  input  dp_op_e                 op_i,
  output dp_stat_t               stat_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [IdW-1:0]         out_id_o,
  output logic signed [KeyW-1:0] out_key_o,
  output logic [StatW-1:0]       status_o,
  output logic [CntW-1:0]        count_out_o
);

  localparam int SW  = $clog2(CAPACITY + 1);
  localparam int IXW = $clog2(ID_COUNT);

  typedef logic signed [KEY_BITS-1:0] hkey_t;

  // heap stores, slot 0 unused
  hkey_t          key_mem [0:CAPACITY];
  logic [IdW-1:0] id_mem  [0:CAPACITY];
  // id to slot map, trusted only when the slot points back at the id
  logic [SW-1:0]  pos_mem [0:ID_COUNT-1];
  // map entries written at least once since reset
  logic [ID_COUNT-1:0] pos_set_q;

  logic          order_q;
  cmd_e          cmd_q;
  logic [IdW-1:0] id_q;
  hkey_t         key_q;
  logic [SW-1:0] count_q, count_d;
  logic [SW-1:0] hole_q, hole_d;
  hkey_t         item_key_q, item_key_d;
  logic [IdW-1:0] item_id_q, item_id_d;
  logic [SW-1:0] pos_q;
  hkey_t         a_key_q, b_key_q;
  logic [IdW-1:0] a_id_q, b_id_q;
  logic [IdW-1:0] res_id_q, res_id_d;
  hkey_t         res_key_q, res_key_d;
  status_e       res_st_q, res_st_d;
  logic          sift_d;

  logic                   out_valid_q;
  logic [IdW-1:0]         out_id_q;
  logic signed [KeyW-1:0] out_key_q;
  logic [StatW-1:0]       out_st_q;
  logic [CntW-1:0]        out_cnt_q;

  logic [SW-1:0] rd_a, rd_b;
  logic          wr_en;
  logic [SW-1:0] wr_slot;
  hkey_t         wr_key;
  logic [IdW-1:0] wr_id;

  logic [SW:0]   child_l;
  logic          use_b;
  hkey_t         c_key;
  logic [IdW-1:0] c_id;
  logic [SW-1:0] c_slot;
  logic          id_ok, present, out_free;

  function automatic logic better(input logic mode, input hkey_t a, input hkey_t b);
    better = mode ? (a > b) : (a < b);
  endfunction

  assign child_l  = {hole_q, 1'b0};
  assign use_b    = (child_l < {1'b0, count_q}) && !better(order_q, a_key_q, b_key_q);
  assign c_key    = use_b ? b_key_q : a_key_q;
  assign c_id     = use_b ? b_id_q : a_id_q;
  assign c_slot   = use_b ? SW'(child_l + 1'b1) : SW'(child_l);
  assign id_ok    = int'(id_q) < ID_COUNT;
  assign present  = id_ok && pos_set_q[IXW'(id_q)] && (pos_q != '0) && (pos_q <= count_q)
                    && (a_id_q == id_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign stat_o.sift_go   = sift_d;
  assign stat_o.hole_root = (hole_q == SW'(1));
  assign stat_o.up_move   = better(order_q, item_key_q, a_key_q);
  assign stat_o.dn_leaf   = child_l > {1'b0, count_q};
  assign stat_o.dn_move   = better(order_q, c_key, item_key_q);
  assign stat_o.out_free  = out_free;

  // read addresses
  always_comb begin
    rd_a = '0;
    rd_b = count_q;
    case (op_i)
      OP_SLOT:  rd_a = (cmd_q == CMD_PEEK || cmd_q == CMD_POP) ? SW'(1) : pos_q;
      OP_UP_RD: rd_a = hole_q >> 1;
      OP_DN_RD: begin
        rd_a = SW'(child_l);
        rd_b = SW'(child_l + 1'b1);
      end
      default: ;
    endcase
  end

  // single write per cycle into heap and map
  always_comb begin
    wr_en   = 1'b0;
    wr_slot = hole_q;
    wr_key  = item_key_q;
    wr_id   = item_id_q;
    case (op_i)
      OP_UP_CMP: begin
        wr_en  = stat_o.up_move;
        wr_key = a_key_q;
        wr_id  = a_id_q;
      end
      OP_DN_CMP: begin
        wr_en  = stat_o.dn_move;
        wr_key = c_key;
        wr_id  = c_id;
      end
      OP_PLACE: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_key_q <= key_mem[rd_a];
    a_id_q  <= id_mem[rd_a];
    b_key_q <= key_mem[rd_b];
    b_id_q  <= id_mem[rd_b];
    pos_q   <= pos_mem[IXW'(id_q)];
    if (wr_en) begin
      key_mem[wr_slot]       <= wr_key;
      id_mem[wr_slot]        <= wr_id;
      pos_mem[IXW'(wr_id)]   <= wr_slot;
    end
  end

  // command decision
  always_comb begin
    count_d    = count_q;
    hole_d     = hole_q;
    item_key_d = key_q;
    item_id_d  = id_q;
    res_id_d   = id_q;
    res_key_d  = '0;
    res_st_d   = ST_OK;
    sift_d     = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        if (!id_ok) begin
          res_st_d = ST_ABSENT;
        end else if (present) begin
          res_st_d = ST_PRESENT;
        end else if (count_q >= SW'(CAPACITY)) begin
          res_st_d = ST_FULL;
        end else begin
          count_d   = count_q + 1'b1;
          hole_d    = count_q + 1'b1;
          res_key_d = key_q;
          sift_d    = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!present) begin
          res_st_d = ST_ABSENT;
        end else begin
          res_key_d  = a_key_q;
          count_d    = count_q - 1'b1;
          item_key_d = b_key_q;
          item_id_d  = b_id_q;
          hole_d     = pos_q;
          sift_d     = pos_q != count_q;
        end
      end
      CMD_UPDATE: begin
        if (!present) begin
          res_st_d = ST_ABSENT;
        end else begin
          hole_d    = pos_q;
          res_key_d = key_q;
          sift_d    = 1'b1;
        end
      end
      CMD_PEEK, CMD_POP: begin
        if (count_q == '0) begin
          res_st_d = ST_EMPTY;
          res_id_d = '0;
        end else begin
          res_id_d  = a_id_q;
          res_key_d = a_key_q;
          if (cmd_q == CMD_POP) begin
            count_d    = count_q - 1'b1;
            item_key_d = b_key_q;
            item_id_d  = b_id_q;
            hole_d     = SW'(1);
            sift_d     = count_q != SW'(1);
          end
        end
      end
      CMD_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pos_set_q   <= '0;
    end else begin
      if (cfg_we_i) order_q <= cfg_wdata_i;
      if (op_i == OP_DECIDE) count_q <= count_d;
      if (wr_en) pos_set_q[IXW'(wr_id)] <= 1'b1;
      if (op_i == OP_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer_i) begin
      cmd_q <= cmd_e'(cmd_i);
      id_q  <= node_id_i;
      key_q <= KEY_BITS'(key_i);
    end
    case (op_i)
      OP_DECIDE: begin
        hole_q     <= hole_d;
        item_key_q <= item_key_d;
        item_id_q  <= item_id_d;
        res_id_q   <= res_id_d;
        res_key_q  <= res_key_d;
        res_st_q   <= res_st_d;
      end
      OP_UP_CMP: if (stat_o.up_move) hole_q <= hole_q >> 1;
      OP_DN_CMP: if (stat_o.dn_move) hole_q <= c_slot;
      OP_FINISH: begin
        if (out_free) begin
          out_id_q  <= res_id_q;
          out_key_q <= KeyW'(res_key_q);
          out_st_q  <= res_st_q;
          out_cnt_q <= CntW'(count_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_id_q;
  assign out_key_o   = out_key_q;
  assign status_o    = out_st_q;
  assign count_out_o = out_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SW'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_DECIDE && cmd_q == CMD_CLEAR) |=> count_q == '0)
    else $error("clear left entries");

  a_hole_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_UP_RD || op_i == OP_DN_RD || op_i == OP_PLACE) |-> hole_q != '0)
    else $error("sift on slot zero");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_IDLE || op_i == OP_FINISH) |-> !wr_en)
    else $error("heap write outside sifting");

endmodule

[rtl/core/indexed_binary_heap.sv]
// channel   | dir | transfer when          | payload
// cmd_i     | in  | valid && ready         | cmd, node_id, key
// res_o     | out | valid && ready         | out_id, out_key, status, count_out
// cfg       | in  | cfg_we_i               | cfg_wdata_i = order_mode
//
// one command at a time: accept, map read, slot read and decide states,
// then the done state; done follows decide directly when nothing is sifted
// sifting: a read and a compare state per level moved; to stop, each direction
// ends on a read state at the root or a leaf, else on a compare; one place state
// each level is a registered memory read followed by a compare and write
// reset clears count, order, the map written flags and the result flag
// a result waits in its register while the next command is accepted; the
// next result then holds the done state until the waiting one is taken
module indexed_binary_heap
  import ibh_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int ID_COUNT = 256,
  parameter int KEY_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  ibh_cmd_if.sink   cmd_i,
  ibh_res_if.source res_o
);

  dp_op_e   op;
  dp_stat_t stat;
  logic     in_ready;

  // command transfer
  assign cmd_i.ready = in_ready;

  ibh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .op_o       (op)
  );

  // heap stores, id map, sift registers and result register
  ibh_datapath #(
    .CAPACITY (CAPACITY),
    .ID_COUNT (ID_COUNT),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_xfer_i   (cmd_i.valid && in_ready),
    .cmd_i       (cmd_i.cmd),
    .node_id_i   (cmd_i.node_id),
    .key_i       (cmd_i.key),
    .op_i        (op),
    .stat_o      (stat),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .out_id_o    (res_o.out_id),
    .out_key_o   (res_o.out_key),
    .status_o    (res_o.status),
    .count_out_o (res_o.count_out)
  );

endmodule
